>>> rtl/packet_reorder_receiver_assert.svh
// Assertion macros for the packet reorder receiver.
`ifndef PACKET_REORDER_RECEIVER_ASSERT_SVH
`define PACKET_REORDER_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/prr_pkg.sv
// Shared types and constants of the packet reorder receiver.
`default_nettype none

package prr_pkg;

  localparam int SEQ_W      = 32;
  localparam int SIZE_W     = 11;
  localparam int HANDLE_W   = 16;
  localparam int KIND_W     = 2;
  localparam int MAXBUF_W   = 6;
  localparam int OCC_W      = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [MAXBUF_W-1:0] MAXBUF_RESET = 6'd63;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_BUFFERED = 1'b0;

  // Packet kinds on the input.
  localparam logic FUNC_FINISH = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DUP     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_EMIT,
    S_ADVANCE,
    S_DRAIN
  } state_t;

  typedef enum logic {
    OP_SUB,
    OP_INC
  } idx_op_t;

  typedef struct packed {
    logic [SEQ_W-1:0] value;
    logic             borrow;
    logic             zero;
  } idx_result_t;

endpackage

`default_nettype wire

>>> rtl/prr_index_unit.sv
// Shared 32-bit index unit: sequence difference and index increment.
`default_nettype none

module prr_index_unit
  import prr_pkg::*;
(
  input  idx_op_t          op,
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output idx_result_t      res
);

  logic [SEQ_W:0] operand;
  logic [SEQ_W:0] sum;

  // Subtraction is a + ~b + 1; increment is a + 0 + 1.
  always_comb begin
    operand = (op == OP_SUB) ? {1'b1, ~b} : '0;
    sum     = {1'b0, a} + operand + {{SEQ_W{1'b0}}, 1'b1};
    res.value  = sum[SEQ_W-1:0];
    // With the one-extended operand the top bit is the sign of a - b.
    res.borrow = (op == OP_SUB) ? sum[SEQ_W] : 1'b0;
    res.zero   = (sum[SEQ_W-1:0] == '0);
  end

endmodule

`default_nettype wire

>>> rtl/packet_reorder_receiver.sv
// Packet reorder receiver: a dropped, stored or ignored item stalls input in S_CLASSIFY.
// An item with results loads its first result into the output register in S_EMIT, after
// S_CLASSIFY and once the output is free; each buffered descriptor released behind it
// passes S_ADVANCE (shared index increment, slot RAM read) and S_DRAIN (transfer).
// Reset clears the expected index, ring head, slot valid bits, occupancy and the
// finished flag at once; max_buffered returns to 63. Slot payload RAM is not cleared.
`default_nettype none

module packet_reorder_receiver
  import prr_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [SEQ_W-1:0]     seq_index,
  input  logic [SIZE_W-1:0]    payload_size,
  input  logic [HANDLE_W-1:0]  payload_handle,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    kind,
  output logic [SEQ_W-1:0]     ack_index,
  output logic [SIZE_W-1:0]    ack_size,
  output logic [HANDLE_W-1:0]  deliver_handle,
  output logic [SIZE_W-1:0]    deliver_size,
  output logic                 last,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int EW = SIZE_W + HANDLE_W;

  state_t state, state_next;

  logic [SEQ_W-1:0]    expected_index;
  logic [AW-1:0]       head;
  logic [WINDOW-1:0]   slot_valid;
  logic [OCC_W-1:0]    occupancy;
  logic                finished;
  logic [MAXBUF_W-1:0] max_buffered;

  logic                func_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [SIZE_W-1:0]   size_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [KIND_W-1:0]   pend_kind;

  logic [EW-1:0]       slot_mem [WINDOW];
  logic [EW-1:0]       rd_data;

  idx_op_t             unit_op;
  idx_result_t         unit_res;

  logic [AW-1:0]       head_inc;
  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot_sel;
  logic                out_free;
  logic                out_take;
  logic                in_take;
  logic                far_future;
  logic                buf_full;

  // Control decoded from state.
  logic                do_finish;
  logic                do_store;
  logic                do_overwrite;
  logic                do_emit;
  logic                do_advance;
  logic                do_drain;
  logic [KIND_W-1:0]   class_kind;

  prr_index_unit u_index (
    .op  (unit_op),
    .a   ((unit_op == OP_SUB) ? seq_q : expected_index),
    .b   (expected_index),
    .res (unit_res)
  );

  assign unit_op  = (state == S_ADVANCE) ? OP_INC : OP_SUB;
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;

  assign head_inc   = (head == AW'(WINDOW - 1)) ? '0 : head + 1'b1;
  assign slot_sum   = {1'b0, head} + {1'b0, unit_res.value[AW-1:0]};
  assign slot_sel   = (slot_sum >= (AW+1)'(WINDOW)) ? AW'(slot_sum - (AW+1)'(WINDOW))
                                                    : slot_sum[AW-1:0];
  assign far_future = (unit_res.value >= SEQ_W'(WINDOW));
  assign buf_full   = (occupancy >= {1'b0, max_buffered});

  always_comb begin
    if (func_q == FUNC_FINISH) begin
      class_kind = KIND_FINISH;
    end else if (unit_res.borrow) begin
      class_kind = KIND_DUP;
    end else begin
      class_kind = KIND_DELIVER;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) state_next = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        if (finished) begin
          state_next = S_IDLE;
        end else if (func_q == FUNC_FINISH || unit_res.borrow || unit_res.zero) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) state_next = (pend_kind == KIND_DELIVER) ? S_ADVANCE : S_IDLE;
      end
      S_ADVANCE: begin
        state_next = slot_valid[head_inc] ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (out_free) state_next = S_ADVANCE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    do_finish    = 1'b0;
    do_store     = 1'b0;
    do_overwrite = 1'b0;
    do_emit      = 1'b0;
    do_advance   = 1'b0;
    do_drain     = 1'b0;
    case (state)
      S_CLASSIFY: begin
        if (!finished) begin
          if (func_q == FUNC_FINISH) begin
            do_finish = 1'b1;
          end else if (!unit_res.borrow && !unit_res.zero && !far_future) begin
            do_overwrite = slot_valid[slot_sel];
            do_store     = !slot_valid[slot_sel] && !buf_full;
          end
        end
      end
      S_EMIT:    do_emit    = out_free;
      S_ADVANCE: do_advance = 1'b1;
      S_DRAIN:   do_drain   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      expected_index <= '0;
      head           <= '0;
      slot_valid     <= '0;
      occupancy      <= '0;
      finished       <= 1'b0;
      max_buffered   <= MAXBUF_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr[2] == REG_MAX_BUFFERED) begin
        max_buffered <= pwdata[MAXBUF_W-1:0];
      end
      if (do_finish) finished <= 1'b1;
      if (do_store) begin
        slot_valid[slot_sel] <= 1'b1;
        occupancy            <= occupancy + 1'b1;
      end
      if (do_advance) begin
        expected_index <= unit_res.value;
        head           <= head_inc;
      end
      if (do_drain) begin
        slot_valid[head] <= 1'b0;
        occupancy        <= occupancy - 1'b1;
      end
      if (do_emit || do_drain) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture and classification result.
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_q   <= func;
      seq_q    <= seq_index;
      size_q   <= payload_size;
      handle_q <= payload_handle;
    end
    if (state == S_CLASSIFY) pend_kind <= class_kind;
  end

  // Slot payload RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_store || do_overwrite) slot_mem[slot_sel] <= {size_q, handle_q};
    if (do_advance) rd_data <= slot_mem[head_inc];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (do_emit) begin
      kind      <= pend_kind;
      ack_index <= seq_q;
      ack_size  <= size_q;
      if (pend_kind == KIND_DELIVER) begin
        deliver_handle <= handle_q;
        deliver_size   <= size_q;
        last           <= !slot_valid[head_inc];
      end else begin
        deliver_handle <= '0;
        deliver_size   <= '0;
        last           <= 1'b1;
      end
    end else if (do_drain) begin
      kind           <= KIND_DELIVER;
      ack_index      <= expected_index;
      ack_size       <= rd_data[EW-1:HANDLE_W];
      deliver_handle <= rd_data[HANDLE_W-1:0];
      deliver_size   <= rd_data[EW-1:HANDLE_W];
      last           <= !slot_valid[head_inc];
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_BUFFERED) begin
      prdata = {{(PDATA_W-MAXBUF_W){1'b0}}, max_buffered};
    end else begin
      prdata = '0;
    end
  end

`include "packet_reorder_receiver_assert.svh"

  `PRR_ASSERT_NOW(a_occ_matches_valid, 1'b1,
                  occupancy == OCC_W'($countones(slot_valid)),
                  "occupancy disagrees with slot valid bits")
  `PRR_ASSERT_NOW(a_drain_slot_valid, state == S_DRAIN, slot_valid[head],
                  "draining a slot that holds no descriptor")
  `PRR_ASSERT_NEXT(a_advance_increments, state == S_ADVANCE,
                   expected_index == $past(expected_index) + 32'd1,
                   "expected index did not advance by one")

endmodule

`default_nettype wire

>>> verif/packet_reorder_receiver_tb.sv
// Self-checking testbench for the packet reorder receiver, with a behavioral predictor.
`timescale 1ns / 1ps

module packet_reorder_receiver_tb;
  import prr_pkg::*;

  localparam int RING_SLOTS = 64;
  localparam int RING_W = $clog2(RING_SLOTS);
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 64;
  localparam logic FUNC_DATA = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    ack_index;
    logic [SIZE_W-1:0]   ack_size;
    logic [HANDLE_W-1:0] deliver_handle;
    logic [SIZE_W-1:0]   deliver_size;
    logic                last;
  } ack_rec_t;

  typedef enum logic [1:0] {
    FROM_MODEL,
    NO_ACK,
    TYPED_ACK
  } ack_source_t;

  typedef struct packed {
    logic                func_bit;
    logic [SEQ_W-1:0]    seq;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    ack_source_t         src;
    ack_rec_t            want;
  } pkt_row_t;

  localparam ack_rec_t NO_REC = '0;

  // Rows 0 to 13 open the run at the reset setting; rows 14 to 17 close it with a finish.
  localparam pkt_row_t STIM_ROWS [0:17] = '{
    '{FUNC_DATA, 32'd0, 11'd0, 16'h0000, TYPED_ACK,
      '{KIND_DELIVER, 32'd0, 11'd0, 16'h0000, 11'd0, 1'b1}},
    '{FUNC_DATA, 32'd0, 11'd2047, 16'hFFFF, TYPED_ACK,
      '{KIND_DUP, 32'd0, 11'd2047, 16'h0000, 11'd0, 1'b1}},
    '{FUNC_DATA, 32'd5, 11'd100, 16'h1234, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'd5, 11'd2047, 16'hFFFF, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'd3, 11'd7, 16'h0003, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'd64, 11'd1, 16'hAAAA, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'd65, 11'd9, 16'h5555, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'd1, 11'd11, 16'h0101, TYPED_ACK,
      '{KIND_DELIVER, 32'd1, 11'd11, 16'h0101, 11'd11, 1'b1}},
    '{FUNC_DATA, 32'd2, 11'd22, 16'h0202, FROM_MODEL, NO_REC},
    '{FUNC_DATA, 32'd4, 11'd44, 16'h0404, FROM_MODEL, NO_REC},
    '{FUNC_DATA, 32'd1, 11'h5A5, 16'h5555, TYPED_ACK,
      '{KIND_DUP, 32'd1, 11'h5A5, 16'h0000, 11'd0, 1'b1}},
    '{FUNC_DATA, 32'd6, 11'd2047, 16'h0000, FROM_MODEL, NO_REC},
    '{FUNC_DATA, 32'h8000_0000, 11'd0, 16'h8000, NO_ACK, NO_REC},
    '{FUNC_FINISH, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF, TYPED_ACK,
      '{KIND_FINISH, 32'hFFFF_FFFF, 11'd2047, 16'h0000, 11'd0, 1'b1}},
    '{FUNC_DATA, 32'd0, 11'd3, 16'h0003, NO_ACK, NO_REC},
    '{FUNC_FINISH, 32'd5, 11'd5, 16'h0005, NO_ACK, NO_REC},
    '{FUNC_DATA, 32'h1234_5678, 11'd8, 16'h0008, NO_ACK, NO_REC}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                func = FUNC_DATA;
  logic [SEQ_W-1:0]    seq_index = '0;
  logic [SIZE_W-1:0]   payload_size = '0;
  logic [HANDLE_W-1:0] payload_handle = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [SEQ_W-1:0]    ack_index;
  logic [SIZE_W-1:0]   ack_size;
  logic [HANDLE_W-1:0] deliver_handle;
  logic [SIZE_W-1:0]   deliver_size;
  logic                last;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor state.
  logic [SEQ_W-1:0]    exp_seq;
  logic                slot_held [RING_SLOTS];
  logic [HANDLE_W-1:0] slot_hdl [RING_SLOTS];
  logic [SIZE_W-1:0]   slot_len [RING_SLOTS];
  int                  held_count;
  logic                rx_finished;
  logic [RING_W-1:0]   ring_head;
  logic [MAXBUF_W-1:0] max_held;

  ack_rec_t    acks_due [$];
  ack_rec_t    new_acks [$];
  ack_source_t row_src = FROM_MODEL;
  ack_rec_t    row_want = '0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          idle_cycles = 0;
  bit          fail_seen = 1'b0;

  packet_reorder_receiver #(
    .WINDOW(RING_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .seq_index(seq_index),
    .payload_size(payload_size),
    .payload_handle(payload_handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .ack_index(ack_index),
    .ack_size(ack_size),
    .deliver_handle(deliver_handle),
    .deliver_size(deliver_size),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the results one packet descriptor causes and leaves them in new_acks.
  function automatic void predict_packet(input logic f, input logic [SEQ_W-1:0] s,
                                         input logic [SIZE_W-1:0] sz,
                                         input logic [HANDLE_W-1:0] h);
    ack_rec_t          r;
    logic [SEQ_W-1:0]  offset;
    logic [RING_W-1:0] slot;
    new_acks.delete();
    if (rx_finished) return;
    if (f == FUNC_FINISH) begin
      rx_finished = 1'b1;
      new_acks.push_back('{KIND_FINISH, s, sz, 16'd0, 11'd0, 1'b1});
    end else if (s < exp_seq) begin
      new_acks.push_back('{KIND_DUP, s, sz, 16'd0, 11'd0, 1'b1});
    end else if (s == exp_seq) begin
      new_acks.push_back('{KIND_DELIVER, s, sz, h, sz, 1'b0});
      exp_seq = exp_seq + 1;
      ring_head = ring_head + 1'b1;
      while (slot_held[ring_head] && new_acks.size() < 64) begin
        new_acks.push_back('{KIND_DELIVER, exp_seq, slot_len[ring_head], slot_hdl[ring_head],
                             slot_len[ring_head], 1'b0});
        slot_held[ring_head] = 1'b0;
        if (held_count > 0) held_count--;
        exp_seq = exp_seq + 1;
        ring_head = ring_head + 1'b1;
      end
      r = new_acks.pop_back();
      r.last = 1'b1;
      new_acks.push_back(r);
    end else begin
      offset = s - exp_seq;
      if (offset < RING_SLOTS) begin
        slot = ring_head + offset[RING_W-1:0];
        // A descriptor already held is replaced without touching the occupancy limit.
        if (slot_held[slot] || held_count < int'(max_held)) begin
          if (!slot_held[slot]) held_count++;
          slot_held[slot] = 1'b1;
          slot_hdl[slot] = h;
          slot_len[slot] = sz;
        end
      end
    end
  endfunction

  function automatic bit field_ok(input string name, input logic [SEQ_W-1:0] want,
                                  input logic [SEQ_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return SIZE_W'($urandom_range(2047));
    endcase
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return HANDLE_W'($urandom());
    endcase
  endfunction

  initial begin
    exp_seq = '0;
    held_count = 0;
    rx_finished = 1'b0;
    ring_head = '0;
    max_held = MAXBUF_RESET;
    for (int i = 0; i < RING_SLOTS; i++) begin
      slot_held[i] = 1'b0;
      slot_hdl[i] = '0;
      slot_len[i] = '0;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Checks results, runs the predictor on every accepted descriptor, and watches for a hang.
  always @(posedge clk) begin
    ack_rec_t want;
    bit       in_xfer;
    bit       out_xfer;
    bit       ok;
    if (!rst) begin
      in_xfer = in_valid && !in_stall;
      out_xfer = out_valid && !out_stall;
      if (out_xfer) begin
        if (acks_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d index %0h size %0d",
                   $time, kind, ack_index, ack_size);
          fail_seen = 1'b1;
        end else begin
          want = acks_due.pop_front();
          ok = field_ok("kind", SEQ_W'(want.kind), SEQ_W'(kind));
          ok &= field_ok("ack_index", want.ack_index, ack_index);
          ok &= field_ok("ack_size", SEQ_W'(want.ack_size), SEQ_W'(ack_size));
          ok &= field_ok("deliver_handle", SEQ_W'(want.deliver_handle), SEQ_W'(deliver_handle));
          ok &= field_ok("deliver_size", SEQ_W'(want.deliver_size), SEQ_W'(deliver_size));
          ok &= field_ok("last", SEQ_W'(want.last), SEQ_W'(last));
          if (!ok) fail_seen = 1'b1;
        end
      end
      if (in_xfer) begin
        predict_packet(func, seq_index, payload_size, payload_handle);
        case (row_src)
          FROM_MODEL: foreach (new_acks[i]) acks_due.push_back(new_acks[i]);
          TYPED_ACK: acks_due.push_back(row_want);
          default: ;
        endcase
      end
      if (in_xfer || out_xfer) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("packet_reorder_receiver verification failed");
          $finish;
        end
      end
    end
  end

  // Called and returns at a falling edge; valid stays high into the next transfer.
  task automatic send_packet(input logic f, input logic [SEQ_W-1:0] s,
                             input logic [SIZE_W-1:0] sz, input logic [HANDLE_W-1:0] h,
                             input ack_source_t src, input ack_rec_t want);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    seq_index <= s;
    payload_size <= sz;
    payload_handle <= h;
    row_src = src;
    row_want = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_rows(input int from, input int to);
    for (int i = from; i <= to; i++) begin
      send_packet(STIM_ROWS[i].func_bit, STIM_ROWS[i].seq, STIM_ROWS[i].size,
                  STIM_ROWS[i].handle, STIM_ROWS[i].src, STIM_ROWS[i].want);
    end
  endtask

  // A stored or dropped descriptor yields nothing, so allow it time to finish after the queue empties.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (acks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_buffered(input logic [MAXBUF_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({REG_MAX_BUFFERED, 2'b00});
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    max_held = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly runs of consecutive indices sent out of order with the expected one last,
  // mixed with duplicates, lone future packets and packets beyond the window.
  task automatic run_phase(input int gap_pct, input int hold_pct, input int limit);
    int               sent;
    int               run_len;
    int               j;
    int               tmp;
    bit               paused;
    int               offs [$];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] s;
    wait_drained();
    write_max_buffered(MAXBUF_W'(limit));
    send_gap_pct = gap_pct;
    stall_pct = hold_pct;
    sent = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      if (!paused && sent >= PHASE_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 8);
        base = exp_seq;
        offs.delete();
        for (int k = 1; k < run_len; k++) offs.push_back(k);
        for (int k = offs.size() - 1; k > 0; k--) begin
          j = $urandom_range(k);
          tmp = offs[k];
          offs[k] = offs[j];
          offs[j] = tmp;
        end
        offs.push_back(0);
        foreach (offs[k]) begin
          send_packet(FUNC_DATA, base + SEQ_W'(offs[k]), pick_size(), pick_handle(),
                      FROM_MODEL, NO_REC);
          sent++;
        end
      end else begin
        case ($urandom_range(3))
          0: s = SEQ_W'($urandom_range(exp_seq - 1));
          1: s = exp_seq + SEQ_W'($urandom_range(1, RING_SLOTS - 1));
          2: s = exp_seq + SEQ_W'($urandom_range(RING_SLOTS, RING_SLOTS + 6));
          default: s = SEQ_W'($urandom());
        endcase
        send_packet(FUNC_DATA, s, pick_size(), pick_handle(), FROM_MODEL, NO_REC);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_rows(0, 13);
    run_phase(0, 0, 1);
    run_phase(48, 0, 63);
    run_phase(0, 48, 37);
    run_phase(25, 25, 2);
    run_phase(0, 0, 63);
    wait_drained();
    run_rows(14, 17);
    wait_drained();
    if (acks_due.size() != 0) fail_seen = 1'b1;
    if (!fail_seen) begin
      $display("packet_reorder_receiver verification clean");
    end else begin
      $display("packet_reorder_receiver verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/prr_pkg.sv
rtl/prr_index_unit.sv
rtl/packet_reorder_receiver.sv
verif/packet_reorder_receiver_tb.sv
